// File: sv/cdd_pkg.sv
package cdd_pkg;

   // Unit codes of the kind field.
   localparam logic [2:0] KIND_DAY        = 3'd0;
   localparam logic [2:0] KIND_WEEK       = 3'd1;
   localparam logic [2:0] KIND_MONTH      = 3'd2;
   localparam logic [2:0] KIND_YEAR       = 3'd3;
   localparam logic [2:0] KIND_DECADE     = 3'd4;
   localparam logic [2:0] KIND_CENTURY    = 3'd5;
   localparam logic [2:0] KIND_MILLENNIUM = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // take a new item from the request ports
      logic day_step;    // count days down or borrow one month
      logic month_step;  // go back one month and count it
      logic set_len;     // day becomes the length of the current month
      logic clamp_len;   // day is clamped to the length of the current month
      logic mul;         // product of count and the unit multiplier
      logic year_sub;    // subtract the product from the year, saturating
      logic capture;     // copy the finished date into the result register
   } cdd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;      // nothing is left to count
      logic day_last;    // the next day step ends inside the current month
   } cdd_status_type;

endpackage

// File: sv/cdd_datapath.sv
module cdd_datapath (
   input  logic                   clock,
   input  cdd_pkg::cdd_cmd_type   cmd,
   output cdd_pkg::cdd_status_type status,
   input  logic [2:0]             req_kind,
   input  logic [14:0]            req_count,
   input  logic [4:0]             req_day,
   input  logic [3:0]             req_month,
   input  logic signed [15:0]     req_year,
   output logic [4:0]             rsp_new_day,
   output logic [3:0]             rsp_new_month,
   output logic signed [15:0]     rsp_new_year,
   output logic                   rsp_year_clipped
);
   import cdd_pkg::*;

   localparam logic signed [15:0] YEAR_MIN = 16'sh8000;
   // Multiplicative inverse of 25 modulo 2**16 and the largest quotient of a 16-bit value.
   localparam logic [15:0] INV25   = 16'h5C29;
   localparam logic [15:0] DIV25_MAX = 16'd2621;
   localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                             5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   // Length of a month; February follows the leap flag, codes outside 1..12 give 31.
   function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      len = 5'd31;
      if (m == 4'd2)
         len = leap ? 5'd29 : 5'd28;
      else if (m >= 4'd1 && m <= 4'd12)
         len = MONTH_LEN[m - 4'd1];
      return len;
   endfunction

   logic [4:0]         day_ff, day_in;
   logic [3:0]         month_ff, month_in;
   logic signed [15:0] year_ff, year_in;
   logic               clip_ff, clip_in;
   logic [17:0]        n_ff, n_in;
   logic [9:0]         mult_ff, mult_in;
   logic [24:0]        prod_ff, prod_in;
   logic [4:0]         out_day_ff;
   logic [3:0]         out_month_ff;
   logic signed [15:0] out_year_ff;
   logic               out_clip_ff;

   // Previous month, with the year borrowed from January and held at its lower bound.
   logic [3:0]         pm_month;
   logic signed [15:0] pm_year;
   logic               pm_clip;

   always_comb begin
      pm_month = month_ff - 4'd1;
      pm_year  = year_ff;
      pm_clip  = clip_ff;
      if (month_ff <= 4'd1) begin
         pm_month = 4'd12;
         if (year_ff != YEAR_MIN)
            pm_year = year_ff - 16'sd1;
         else
            pm_clip = 1'b1;
      end else if (month_ff > 4'd12) begin
         pm_month = 4'd12;
      end
   end

   // Leap test: divisible by 25 is found by the inverse product, the powers of two by low bits.
   logic [15:0] abs_year;
   logic [31:0] inv_prod;
   logic        div25;
   logic        leap;
   logic [4:0]  cur_len;

   always_comb begin
      abs_year = year_ff[15] ? (~year_ff + 16'd1) : year_ff;
      inv_prod = {16'd0, abs_year} * {16'd0, INV25};
      div25    = inv_prod[15:0] <= DIV25_MAX;
      leap     = (div25 && year_ff[3:0] == 4'd0) || (!div25 && year_ff[1:0] == 2'd0);
      cur_len  = days_in(month_ff, leap);
   end

   // Day step: a day of zero borrows like day one.
   logic [5:0] e_val;
   logic       day_last;

   always_comb begin
      e_val    = (day_ff == 5'd0) ? 6'd1 : {1'b0, day_ff};
      day_last = n_ff < {12'd0, e_val};
   end

   // Year subtraction in a range wide enough for the largest product.
   logic signed [26:0] year_diff;

   always_comb begin
      year_diff = {{11{year_ff[15]}}, year_ff} - $signed({2'b00, prod_ff});
   end

   // Next values of the working registers.
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      clip_in  = clip_ff;
      n_in     = n_ff;
      mult_in  = mult_ff;
      prod_in  = prod_ff;
      if (cmd.load) begin
         day_in   = req_day;
         month_in = req_month;
         year_in  = req_year;
         clip_in  = 1'b0;
         if (req_kind == KIND_WEEK)
            n_in = {req_count, 3'b000} - {3'b000, req_count};
         else
            n_in = {3'b000, req_count};
         case (req_kind)
            KIND_DECADE:     mult_in = 10'd10;
            KIND_CENTURY:    mult_in = 10'd100;
            KIND_MILLENNIUM: mult_in = 10'd1000;
            default:         mult_in = 10'd1;
         endcase
      end
      if (cmd.day_step) begin
         if (day_last) begin
            day_in = day_ff - n_ff[4:0];
            n_in   = '0;
         end else begin
            n_in     = n_ff - {12'd0, e_val};
            month_in = pm_month;
            year_in  = pm_year;
            clip_in  = pm_clip;
         end
      end
      if (cmd.month_step) begin
         n_in     = n_ff - 18'd1;
         month_in = pm_month;
         year_in  = pm_year;
         clip_in  = pm_clip;
      end
      if (cmd.set_len)
         day_in = cur_len;
      if (cmd.clamp_len && day_ff > cur_len)
         day_in = cur_len;
      if (cmd.mul)
         prod_in = {10'd0, n_ff[14:0]} * {15'd0, mult_ff};
      if (cmd.year_sub) begin
         if (year_diff < -27'sd32768) begin
            year_in = YEAR_MIN;
            clip_in = 1'b1;
         end else begin
            year_in = year_diff[15:0];
         end
      end
   end

   // Working registers and the result register.
   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      clip_ff  <= clip_in;
      n_ff     <= n_in;
      mult_ff  <= mult_in;
      prod_ff  <= prod_in;
      if (cmd.capture) begin
         out_day_ff   <= day_ff;
         out_month_ff <= month_ff;
         out_year_ff  <= year_ff;
         out_clip_ff  <= clip_ff;
      end
   end

   assign status.n_zero   = n_ff == 18'd0;
   assign status.day_last = day_last;

   assign rsp_new_day      = out_day_ff;
   assign rsp_new_month    = out_month_ff;
   assign rsp_new_year     = out_year_ff;
   assign rsp_year_clipped = out_clip_ff;

endmodule

// File: sv/cdd_controller.sv
module cdd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_kind,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  cdd_pkg::cdd_status_type status,
   output cdd_pkg::cdd_cmd_type    cmd
);
   import cdd_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DAY_STEP,
      DAY_FIX,
      MONTH_STEP,
      MONTH_FIX,
      YEAR_MUL,
      YEAR_SUB,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequencing of one item and handover to the result register.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_kind) inside
                  KIND_DAY, KIND_WEEK:                  state_in = DAY_STEP;
                  KIND_MONTH:                           state_in = MONTH_STEP;
                  [KIND_YEAR:KIND_MILLENNIUM]:          state_in = YEAR_MUL;
                  default:                              state_in = DONE;
               endcase
            end
         end
         DAY_STEP: begin
            if (status.n_zero) begin
               state_in = DONE;
            end else begin
               cmd.day_step = 1'b1;
               state_in     = status.day_last ? DONE : DAY_FIX;
            end
         end
         DAY_FIX: begin
            cmd.set_len = 1'b1;
            state_in    = DAY_STEP;
         end
         MONTH_STEP: begin
            if (status.n_zero) begin
               state_in = DONE;
            end else begin
               cmd.month_step = 1'b1;
               state_in       = MONTH_FIX;
            end
         end
         MONTH_FIX: begin
            cmd.clamp_len = 1'b1;
            state_in      = MONTH_STEP;
         end
         YEAR_MUL: begin
            cmd.mul  = 1'b1;
            state_in = YEAR_SUB;
         end
         YEAR_SUB: begin
            cmd.year_sub = 1'b1;
            state_in     = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/calendar_date_decrement.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_kind, req_count, req_day, req_month, req_year
// rsp       out        rsp_valid/rsp_stall rsp_new_day, rsp_new_month, rsp_new_year,
//                                          rsp_year_clipped
//
// One item is worked at a time by a state machine over a shared datapath.
// Day and week items pass DAY_STEP and DAY_FIX once per month borrowed; month items pass
// MONTH_STEP and MONTH_FIX per month; year to millennium items pass YEAR_MUL and YEAR_SUB.
// The month borrow loop sets the rate: one month step and one length lookup per pass.
// Reset is synchronous and clears the controller; a finished result waits in the output
// register under rsp_stall while the next item is accepted and worked.
module calendar_date_decrement (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [14:0]        req_count,
   input  logic [4:0]         req_day,
   input  logic [3:0]         req_month,
   input  logic signed [15:0] req_year,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_new_day,
   output logic [3:0]         rsp_new_month,
   output logic signed [15:0] rsp_new_year,
   output logic               rsp_year_clipped
);
   import cdd_pkg::*;

   cdd_cmd_type    cmd;
   cdd_status_type status;

   // Sequencer.
   cdd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Date registers and arithmetic.
   cdd_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_count        (req_count),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .rsp_new_day      (rsp_new_day),
      .rsp_new_month    (rsp_new_month),
      .rsp_new_year     (rsp_new_year),
      .rsp_year_clipped (rsp_year_clipped)
   );

   // An accepted item keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting an item");

   // A clipped result always carries the lowest year.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_year_clipped) |-> (rsp_new_year == 16'sh8000))
      else $error("clipped result with a year above the lower bound");

   // A new result only appears after the block has been working on an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

endmodule
